FILE: src/psfd_pkg.sv
`timescale 1ns / 1ps
// Package: shared types and constants of the per-source flood detector.
package psfd_pkg;

   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned TIME_W   = 48;
   localparam int unsigned COUNT_W  = 20;
   localparam int unsigned SPAN_W   = 36;
   localparam int unsigned WINDOW_W = 16;
   localparam int unsigned LIMIT_W  = 36;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0]  US_PER_S          = 20'd1000000;
   localparam logic [COUNT_W-1:0]  THRESHOLD_RESET   = 20'd100;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET       = 36'd1000000;

   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH   = 8'd1;

   typedef enum logic {
      PSFD_IDLE,
      PSFD_UPDATE
   } psfd_state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  win_begin;
   } bucket_entry_type;

endpackage

FILE: src/psfd_if.sv
`timescale 1ns / 1ps
// Interfaces: packet request, alert result and register write channels.
interface psfd_req_if;
   logic                         valid;
   logic                         ready;
   logic [psfd_pkg::ADDR_W-1:0]  source_addr;
   logic [psfd_pkg::TIME_W-1:0]  time_us;
   modport source (output valid, output source_addr, output time_us, input ready);
   modport sink   (input valid, input source_addr, input time_us, output ready);
endinterface

interface psfd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          alert;
   logic [psfd_pkg::ADDR_W-1:0]   alert_addr;
   logic [psfd_pkg::COUNT_W-1:0]  alert_count;
   logic [psfd_pkg::TIME_W-1:0]   first_seen_us;
   logic [psfd_pkg::TIME_W-1:0]   last_seen_us;
   logic [psfd_pkg::SPAN_W-1:0]   span_us;
   modport source (output valid, output alert, output alert_addr, output alert_count,
                   output first_seen_us, output last_seen_us, output span_us,
                   input ready);
   modport sink   (input valid, input alert, input alert_addr, input alert_count,
                   input first_seen_us, input last_seen_us, input span_us,
                   output ready);
endinterface

interface psfd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [psfd_pkg::CSR_IDX_W-1:0]   index;
   logic [psfd_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/psfd_key_table.sv
`timescale 1ns / 1ps
// Key table: register-held source keys, parallel match and slot claim.
module psfd_key_table #(
   parameter int unsigned BUCKETS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               lookup,
   input  logic [psfd_pkg::ADDR_W-1:0]        addr,
   output logic                               hit,
   output logic [$clog2(BUCKETS)-1:0]         slot
);
   localparam int unsigned IDX_W = $clog2(BUCKETS);
   localparam int unsigned USE_W = $clog2(BUCKETS + 1);

   logic [psfd_pkg::ADDR_W-1:0] key_ff [BUCKETS];
   logic [USE_W-1:0]            used_ff;
   logic [USE_W-1:0]            used_in;
   logic [IDX_W-1:0]            repl_ff;
   logic [IDX_W-1:0]            repl_in;
   logic [IDX_W-1:0]            hit_slot;
   logic [IDX_W-1:0]            claim_slot;
   logic                        full;

   // Keys are unique in the table, so at most one entry matches.
   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = 0; i < BUCKETS; i++) begin
         if ((USE_W'(i) < used_ff) && (key_ff[i] == addr)) begin
            hit      = 1'b1;
            hit_slot = hit_slot | IDX_W'(i);
         end
      end
   end

   assign full       = (used_ff == USE_W'(BUCKETS));
   assign claim_slot = full ? repl_ff : used_ff[IDX_W-1:0];
   assign slot       = hit ? hit_slot : claim_slot;

   always_comb begin
      used_in = used_ff;
      repl_in = repl_ff;
      if (lookup && !hit) begin
         if (!full) begin
            used_in = used_ff + USE_W'(1);
         end else if (repl_ff == IDX_W'(BUCKETS - 1)) begin
            repl_in = '0;
         end else begin
            repl_in = repl_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         repl_ff <= '0;
      end else begin
         used_ff <= used_in;
         repl_ff <= repl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lookup && !hit) begin
         key_ff[claim_slot] <= addr;
      end
   end

endmodule

FILE: src/per_source_flood_detector_core.sv
`timescale 1ns / 1ps
// Top level: per-source fixed-window packet rate counter with alert output.
//
//  channel   | role   | payload
//  ----------+--------+---------------------------------------------------------
//  req_ch    | sink   | source_addr[31:0], time_us[47:0]
//  rsp_ch    | source | alert, alert_addr, alert_count, first_seen_us,
//            |        | last_seen_us, span_us
//  csr_ch    | sink   | index[7:0] (0 threshold, 1 window seconds), data[31:0]
//
// For each packet, the accept cycle matches the key against the
// register-held keys and reads the bucket memory; the next cycle updates
// count and window start, writes the bucket back and loads the result register.
// Reset clears slot usage and the replace pointer; bucket contents need no
// clearing. A stalled result holds the next packet off until the result transfer
// completes or is completing.
module per_source_flood_detector_core #(
   parameter int unsigned BUCKETS = 64
) (
   input  logic               clock,
   input  logic               reset,
   psfd_req_if.sink           req_ch,
   psfd_rsp_if.source         rsp_ch,
   psfd_csr_if.sink           csr_ch
);
   localparam int unsigned IDX_W = $clog2(BUCKETS);

   // Configuration: threshold, and window length kept as microseconds.
   logic [psfd_pkg::COUNT_W-1:0] thresh_ff;
   logic [psfd_pkg::LIMIT_W-1:0] limit_ff;
   logic [psfd_pkg::LIMIT_W-1:0] limit_in;

   assign csr_ch.ready = 1'b1;
   assign limit_in = {20'd0, csr_ch.data[psfd_pkg::WINDOW_W-1:0]}
                   * {16'd0, psfd_pkg::US_PER_S};

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= psfd_pkg::THRESHOLD_RESET;
         limit_ff  <= psfd_pkg::LIMIT_RESET;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == psfd_pkg::CSR_ALERT_THRESHOLD) begin
            thresh_ff <= csr_ch.data[psfd_pkg::COUNT_W-1:0];
         end else if (csr_ch.index == psfd_pkg::CSR_WINDOW_LENGTH) begin
            limit_ff <= limit_in;
         end
      end
   end

   // Sequencer.
   psfd_pkg::psfd_state_type state_ff, state_in;
   logic req_xfer;
   logic upd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psfd_pkg::PSFD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      upd_en       = 1'b0;
      unique case (state_ff)
         psfd_pkg::PSFD_IDLE: begin
            // Accept only when the result register is free by the update cycle.
            req_ch.ready = !rsp_ch.valid || rsp_ch.ready;
            if (req_ch.valid && req_ch.ready) begin
               state_in = psfd_pkg::PSFD_UPDATE;
            end
         end
         psfd_pkg::PSFD_UPDATE: begin
            upd_en   = 1'b1;
            state_in = psfd_pkg::PSFD_IDLE;
         end
         default: state_in = psfd_pkg::PSFD_IDLE;
      endcase
   end

   assign req_xfer = req_ch.valid && req_ch.ready;

   // Key lookup and slot claim.
   logic             hit;
   logic [IDX_W-1:0] slot;

   psfd_key_table #(.BUCKETS(BUCKETS)) u_keys (
      .clock  (clock),
      .reset  (reset),
      .lookup (req_xfer),
      .addr   (req_ch.source_addr),
      .hit    (hit),
      .slot   (slot)
   );

   // Hold the packet for the update cycle.
   logic [psfd_pkg::ADDR_W-1:0] addr_ff;
   logic [psfd_pkg::TIME_W-1:0] time_ff;
   logic [IDX_W-1:0]            slot_ff;
   logic                        hit_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         addr_ff <= req_ch.source_addr;
         time_ff <= req_ch.time_us;
         slot_ff <= slot;
         hit_ff  <= hit;
      end
   end

   // Bucket memory: count and window start, with a registered read.
   // A write lands before the next packet's read, so no forwarding is needed.
   psfd_pkg::bucket_entry_type bucket_mem [BUCKETS];
   psfd_pkg::bucket_entry_type rd_ff;
   psfd_pkg::bucket_entry_type wr_entry;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rd_ff <= bucket_mem[slot];
      end
      if (upd_en) begin
         bucket_mem[slot_ff] <= wr_entry;
      end
   end

   // Update: a freshly claimed slot starts empty at the packet time.
   psfd_pkg::bucket_entry_type cur;
   logic [psfd_pkg::TIME_W:0]    diff_full;
   logic [psfd_pkg::TIME_W-1:0]  diff;
   logic                         behind;
   logic                         restart;
   logic [psfd_pkg::COUNT_W-1:0] cnt_base;
   logic [psfd_pkg::COUNT_W-1:0] cnt;
   logic                         alert;
   logic [psfd_pkg::TIME_W-1:0]  win_first;
   logic [psfd_pkg::SPAN_W-1:0]  span;

   always_comb begin
      cur = hit_ff ? rd_ff
                   : psfd_pkg::bucket_entry_type'{count: '0, win_begin: time_ff};
      diff_full = {1'b0, time_ff} - {1'b0, cur.win_begin};
      behind    = diff_full[psfd_pkg::TIME_W];
      diff      = diff_full[psfd_pkg::TIME_W-1:0];
      restart   = !behind && (diff > {12'd0, limit_ff});
      cnt_base  = restart ? '0 : cur.count;
      cnt       = (cnt_base == '1) ? cnt_base : cnt_base + 20'd1;
      alert     = (cnt >= thresh_ff);
      win_first = restart ? time_ff : cur.win_begin;
      // Span is zero after a restart or when time ran backwards; saturate long spans.
      if (restart || behind) begin
         span = '0;
      end else if (|diff[psfd_pkg::TIME_W-1:psfd_pkg::SPAN_W]) begin
         span = '1;
      end else begin
         span = diff[psfd_pkg::SPAN_W-1:0];
      end
      if (alert) begin
         wr_entry = '{count: '0, win_begin: time_ff};
      end else begin
         wr_entry = '{count: cnt, win_begin: win_first};
      end
   end

   // Result register.
   logic                         rsp_valid_ff;
   logic                         alert_ff;
   logic [psfd_pkg::ADDR_W-1:0]  alert_addr_ff;
   logic [psfd_pkg::COUNT_W-1:0] count_ff;
   logic [psfd_pkg::TIME_W-1:0]  first_ff;
   logic [psfd_pkg::TIME_W-1:0]  last_ff;
   logic [psfd_pkg::SPAN_W-1:0]  span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_en) begin
         alert_ff      <= alert;
         alert_addr_ff <= alert ? addr_ff    : '0;
         count_ff      <= alert ? cnt        : '0;
         first_ff      <= alert ? win_first  : '0;
         last_ff       <= alert ? time_ff    : '0;
         span_ff       <= alert ? span       : '0;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.alert         = alert_ff;
   assign rsp_ch.alert_addr    = alert_addr_ff;
   assign rsp_ch.alert_count   = count_ff;
   assign rsp_ch.first_seen_us = first_ff;
   assign rsp_ch.last_seen_us  = last_ff;
   assign rsp_ch.span_us       = span_ff;

endmodule
